// ===== rtl/lpm_pkg.sv =====
`default_nettype none

package lpm_pkg;

	// Table geometry and field widths.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ADDR_W = 32;
	localparam int SLOT_W = 5;
	localparam int LEN_W = 6;

	typedef logic [IDX_W-1:0] idx_t;

	// Request opcodes.
	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_EMIT
	} state_t;

	// One stored route: destination already masked, mask, and prefix length.
	typedef struct packed {
		logic [ADDR_W-1:0] dm;
		logic [ADDR_W-1:0] mask;
		logic [LEN_W-1:0]  len;
	} route_t;

	typedef struct packed {
		logic   en;
		idx_t   idx;
		logic   valid;
		route_t route;
	} tbl_wr_t;

	typedef struct packed {
		logic en;
		idx_t idx;
	} tbl_rd_t;

	typedef struct packed {
		logic   valid;
		route_t route;
	} tbl_rd_data_t;

	// Population count of a 32-bit mask as a balanced adder tree.
	function automatic logic [LEN_W-1:0] popcount(input logic [ADDR_W-1:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lpm_if.sv =====
`default_nettype none

// Request channel: table writes and address lookups.
interface lpm_req_if;
	logic                         valid;
	logic                         ready;
	lpm_pkg::action_t             action;
	logic [lpm_pkg::SLOT_W-1:0]   entry_index;
	logic [lpm_pkg::ADDR_W-1:0]   entry_dest;
	logic [lpm_pkg::ADDR_W-1:0]   entry_mask;
	logic                         entry_valid;
	logic [lpm_pkg::ADDR_W-1:0]   lookup_address;

	modport source (
		output valid, action, entry_index, entry_dest, entry_mask, entry_valid,
			lookup_address,
		input  ready
	);
	modport sink (
		input  valid, action, entry_index, entry_dest, entry_mask, entry_valid,
			lookup_address,
		output ready
	);
endinterface

// Response channel: one lookup result.
interface lpm_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [lpm_pkg::SLOT_W-1:0] match_index;
	logic [lpm_pkg::LEN_W-1:0]  match_length;

	modport source (
		output valid, found, match_index, match_length,
		input  ready
	);
	modport sink (
		input  valid, found, match_index, match_length,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/lpm_table.sv =====
`default_nettype none

module lpm_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lpm_pkg::tbl_wr_t      wr,
	input  lpm_pkg::tbl_rd_t      rd,
	output lpm_pkg::tbl_rd_data_t rd_data
);

	lpm_pkg::route_t                   mem [lpm_pkg::TABLE_DEPTH];
	logic [lpm_pkg::TABLE_DEPTH-1:0]   vld_q;
	lpm_pkg::route_t                   rd_route_q;
	logic                              rd_vld_q;

	// Route storage: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.route;
		end
		if (rd.en) begin
			rd_route_q <= mem[rd.idx];
			rd_vld_q   <= vld_q[rd.idx];
		end
	end

	// Valid marks are flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= wr.valid;
		end
	end

	assign rd_data.valid = rd_vld_q;
	assign rd_data.route = rd_route_q;

endmodule

`default_nettype wire

// ===== rtl/lpm_ctrl.sv =====
`default_nettype none

module lpm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	lpm_req_if.sink               req,
	lpm_rsp_if.source             rsp,
	output lpm_pkg::tbl_wr_t      wr,
	output lpm_pkg::tbl_rd_t      rd,
	input  lpm_pkg::tbl_rd_data_t rd_data
);

	lpm_pkg::state_t                state_q;
	lpm_pkg::state_t                state_d;
	lpm_pkg::idx_t                  cnt_q;
	lpm_pkg::idx_t                  idx_s1;
	logic                           cmp_s1;
	logic [lpm_pkg::ADDR_W-1:0]     addr_q;
	logic                           hit_q;
	lpm_pkg::idx_t                  best_idx_q;
	logic [lpm_pkg::LEN_W-1:0]      best_len_q;
	logic                           out_valid_q;
	logic                           found_q;
	logic [lpm_pkg::SLOT_W-1:0]     out_idx_q;
	logic [lpm_pkg::LEN_W-1:0]      out_len_q;

	logic req_fire;
	logic lookup_fire;
	logic write_fire;
	logic in_range;
	logic last_cnt;
	logic out_free;
	logic load_out;
	logic match;
	logic better;

	// Request decode.
	assign req_fire    = req.valid && req.ready;
	assign lookup_fire = req_fire && (req.action == lpm_pkg::ACT_LOOKUP);
	assign write_fire  = req_fire && (req.action == lpm_pkg::ACT_WRITE);
	assign in_range    = {{(32 - lpm_pkg::SLOT_W){1'b0}}, req.entry_index}
		< 32'(lpm_pkg::TABLE_DEPTH);
	assign last_cnt    = cnt_q == lpm_pkg::idx_t'(lpm_pkg::TABLE_DEPTH - 1);
	assign out_free    = !out_valid_q || rsp.ready;

	// Compare the entry read last cycle against the lookup address.
	assign match  = cmp_s1 && rd_data.valid
		&& ((addr_q & rd_data.route.mask) == rd_data.route.dm);
	assign better = match && (!hit_q || (rd_data.route.len > best_len_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpm_pkg::ST_IDLE: begin
				if (lookup_fire) begin
					state_d = lpm_pkg::ST_SCAN;
				end
			end
			lpm_pkg::ST_SCAN: begin
				if (last_cnt) begin
					state_d = lpm_pkg::ST_LAST;
				end
			end
			lpm_pkg::ST_LAST: begin
				state_d = lpm_pkg::ST_EMIT;
			end
			lpm_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = lpm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lpm_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: request handshake, table read and write ports.
	always_comb begin
		req.ready     = state_q == lpm_pkg::ST_IDLE;
		load_out      = (state_q == lpm_pkg::ST_EMIT) && out_free;
		rd.en         = state_q == lpm_pkg::ST_SCAN;
		rd.idx        = cnt_q;
		wr.en         = write_fire && in_range;
		wr.idx        = lpm_pkg::idx_t'(req.entry_index);
		wr.valid      = req.entry_valid;
		wr.route.dm   = req.entry_dest & req.entry_mask;
		wr.route.mask = req.entry_mask;
		wr.route.len  = lpm_pkg::popcount(req.entry_mask);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpm_pkg::ST_IDLE;
			cnt_q       <= '0;
			cmp_s1      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_s1  <= state_q == lpm_pkg::ST_SCAN;
			if (lookup_fire) begin
				cnt_q <= '0;
			end else if (state_q == lpm_pkg::ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (lookup_fire) begin
				hit_q <= 1'b0;
			end else if (better) begin
				hit_q <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Scan datapath and result register.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (lookup_fire) begin
			addr_q     <= req.lookup_address;
			best_idx_q <= '0;
			best_len_q <= '0;
		end else if (better) begin
			best_idx_q <= idx_s1;
			best_len_q <= rd_data.route.len;
		end
		if (load_out) begin
			found_q   <= hit_q;
			out_idx_q <= lpm_pkg::SLOT_W'(best_idx_q);
			out_len_q <= best_len_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = found_q;
	assign rsp.match_index  = out_idx_q;
	assign rsp.match_length = out_len_q;

endmodule

`default_nettype wire

// ===== rtl/longest_prefix_match_top.sv =====
// Channel   Modport            Moves                                   Per request
// req       lpm_req_if.sink    table write or address lookup           one in
// rsp       lpm_rsp_if.source  found, match_index, match_length        one per lookup
//
// A write is taken while idle, and the next request may follow at once.
// A lookup reads the route memory one entry per cycle, so it occupies the
// block through ST_SCAN, ST_LAST and ST_EMIT until the next request is taken.
// The result sits in an output register; a stalled rsp holds the next
// lookup in ST_EMIT and blocks requests there; writes are taken until then.
// Reset clears all valid marks at once; no clearing pass is needed.
`default_nettype none

module longest_prefix_match_top (
	input  logic       clk,
	input  logic       arst_n,
	lpm_req_if.sink    req,
	lpm_rsp_if.source  rsp
);

	lpm_pkg::tbl_wr_t      tbl_wr;
	lpm_pkg::tbl_rd_t      tbl_rd;
	lpm_pkg::tbl_rd_data_t tbl_rd_data;

	// Sequencer, compare and result register.
	lpm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rd_data)
	);

	// Route memory and valid marks.
	lpm_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_rd_data)
	);

endmodule

`default_nettype wire

// ===== rtl/lpm_checker.sv =====
`default_nettype none

module lpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       req_action,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       rsp_found,
	input logic [lpm_pkg::SLOT_W-1:0] rsp_match_index,
	input logic [lpm_pkg::LEN_W-1:0]  rsp_match_length
);

	// A stalled result stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its value.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_match_index)
			&& $stable(rsp_match_length))
		else $error("result changed while stalled");

	// A miss reports zero slot and zero length.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_match_index == '0 && rsp_match_length == '0)
		else $error("miss with nonzero slot or length");

	// A lookup occupies the block for the scan that follows.
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == lpm_pkg::ACT_LOOKUP |=> !req_ready)
		else $error("request taken during a scan");

	// A write leaves the block ready for the next request.
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == lpm_pkg::ACT_WRITE |=> req_ready)
		else $error("block stalled after a write");

endmodule

bind longest_prefix_match_top lpm_checker u_lpm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_action       (req.action),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_found        (rsp.found),
	.rsp_match_index  (rsp.match_index),
	.rsp_match_length (rsp.match_length)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 150;
	localparam int DIRECTED_ROWS = 21;

	// One request of the directed table, with the typed-in result where there is one.
	typedef struct packed {
		lpm_pkg::action_t           action;
		logic [lpm_pkg::SLOT_W-1:0] slot;
		logic [lpm_pkg::ADDR_W-1:0] dest;
		logic [lpm_pkg::ADDR_W-1:0] mask;
		logic                       live;
		logic [lpm_pkg::ADDR_W-1:0] addr;
		logic                       typed;
		logic                       found;
		logic [lpm_pkg::SLOT_W-1:0] idx;
		logic [lpm_pkg::LEN_W-1:0]  len;
	} route_row_t;

	// One lookup result.
	typedef struct packed {
		logic                       found;
		logic [lpm_pkg::SLOT_W-1:0] idx;
		logic [lpm_pkg::LEN_W-1:0]  len;
	} route_hit_t;

	// Default route, full-length host route, ties, removal and a non-contiguous mask.
	localparam route_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
			1'b1, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
			1'b1, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h1234_5678,
			1'b1, 1'b1, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF,
			1'b1, 1'b1, 5'd31, 6'd32},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFE,
			1'b1, 1'b1, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd5,  32'h0A00_0000, 32'hFF00_0000, 1'b1, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd3,  32'h0A00_00FF, 32'hFF00_0000, 1'b1, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0A12_3456,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd7,  32'h0A0A_0000, 32'hFFFF_0000, 1'b1, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0A0A_0101,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd7,  32'h0A0A_0000, 32'hFFFF_0000, 1'b0, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0A0A_0101,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd9,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h5555_5555,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd31, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_WRITE,  5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
			1'b0, 1'b0, 5'd0, 6'd0},
		'{lpm_pkg::ACT_LOOKUP, 5'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF,
			1'b0, 1'b0, 5'd0, 6'd0}
	};

	logic clk;
	logic arst_n;

	lpm_req_if req_ch ();
	lpm_rsp_if rsp_ch ();

	longest_prefix_match_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the routing table.
	logic [lpm_pkg::ADDR_W-1:0] shadow_dest [lpm_pkg::TABLE_DEPTH];
	logic [lpm_pkg::ADDR_W-1:0] shadow_mask [lpm_pkg::TABLE_DEPTH];
	bit                         shadow_live [lpm_pkg::TABLE_DEPTH];

	route_hit_t pending_hits [$];
	logic [lpm_pkg::ADDR_W-1:0] prefix_pool [4];

	int  mismatches = 0;
	int  lookups_accepted = 0;
	int  cycle_count = 0;
	int  send_max_gap = 10;
	int  rsp_max_gap = 10;
	int  rsp_stall = 0;
	logic rsp_hold;

	// Clock with a 10 ns period.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Longest match over the valid routes; on equal length the lowest slot stays.
	function automatic route_hit_t best_route(input logic [lpm_pkg::ADDR_W-1:0] addr);
		route_hit_t hit;
		int         len;
		hit = '0;
		for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
			if (shadow_live[i] &&
					((addr & shadow_mask[i]) == (shadow_dest[i] & shadow_mask[i]))) begin
				len = $countones(shadow_mask[i]);
				if (!hit.found || len > hit.len) begin
					hit.found = 1'b1;
					hit.idx = lpm_pkg::SLOT_W'(i);
					hit.len = lpm_pkg::LEN_W'(len);
				end
			end
		end
		return hit;
	endfunction

	// Offer one request after a random gap, wait for it to be taken, then
	// update the shadow table or queue the expected lookup result.
	task automatic issue_request(input route_row_t row);
		int gap;
		gap = $urandom_range(0, send_max_gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= row.action;
		req_ch.entry_index <= row.slot;
		req_ch.entry_dest <= row.dest;
		req_ch.entry_mask <= row.mask;
		req_ch.entry_valid <= row.live;
		req_ch.lookup_address <= row.addr;
		do @(posedge clk); while (!req_ch.ready);
		if (row.action == lpm_pkg::ACT_WRITE) begin
			if (row.slot < lpm_pkg::TABLE_DEPTH) begin
				shadow_dest[row.slot] = row.dest;
				shadow_mask[row.slot] = row.mask;
				shadow_live[row.slot] = row.live;
			end
		end else begin
			if (row.typed) begin
				pending_hits.push_back(route_hit_t'{row.found, row.idx, row.len});
			end else begin
				pending_hits.push_back(best_route(row.addr));
			end
			lookups_accepted++;
		end
	endtask

	// Result side: random stalls per result, plus one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_hits.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: unexpected result found=%0d index=%0d length=%0d",
							$time, rsp_ch.found, rsp_ch.match_index, rsp_ch.match_length);
					end
					mismatches++;
				end else begin
					route_hit_t exp_hit;
					exp_hit = pending_hits.pop_front();
					if (rsp_ch.found !== exp_hit.found || rsp_ch.match_index !== exp_hit.idx ||
							rsp_ch.match_length !== exp_hit.len) begin
						if (mismatches < 10) begin
							$display("%0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								$time, exp_hit.found, exp_hit.idx, exp_hit.len,
								rsp_ch.found, rsp_ch.match_index, rsp_ch.match_length);
						end
						mismatches++;
					end
				end
				rsp_stall = $urandom_range(0, rsp_max_gap);
			end else if (rsp_stall > 0) begin
				rsp_stall--;
			end
			rsp_ch.ready <= !rsp_hold && (rsp_stall == 0);
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	// Hold the result side off long enough for the block to back up its input.
	initial begin
		rsp_hold = 1'b0;
		wait (lookups_accepted >= 60);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Reset, directed table, then four random phases.
	initial begin
		route_row_t row;
		int         len;
		for (int i = 0; i < lpm_pkg::TABLE_DEPTH; i++) begin
			shadow_live[i] = 1'b0;
		end
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= lpm_pkg::ACT_WRITE;
		req_ch.entry_index <= '0;
		req_ch.entry_dest <= '0;
		req_ch.entry_mask <= '0;
		req_ch.entry_valid <= 1'b0;
		req_ch.lookup_address <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			issue_request(DIRECTED[r]);
		end

		for (int phase = 0; phase < 4; phase++) begin
			// Phases alternate between idling on both sides, none, and one side only.
			case (phase)
				0: begin
					send_max_gap = 10;
					rsp_max_gap = 10;
				end
				1: begin
					send_max_gap = 0;
					rsp_max_gap = 0;
				end
				2: begin
					send_max_gap = 10;
					rsp_max_gap = 0;
				end
				default: begin
					send_max_gap = 0;
					rsp_max_gap = 10;
				end
			endcase
			if (phase == 2) begin
				// Let every outstanding lookup come back before going on.
				req_ch.valid <= 1'b0;
				while (pending_hits.size() != 0) @(posedge clk);
				@(posedge clk);
			end
			// Fresh base prefixes so that routes of different lengths nest.
			for (int k = 0; k < 4; k++) begin
				prefix_pool[k] = $urandom;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				row = '0;
				row.action = ($urandom_range(0, 99) < 35) ? lpm_pkg::ACT_WRITE
					: lpm_pkg::ACT_LOOKUP;
				row.slot = lpm_pkg::SLOT_W'($urandom_range(0, 31));
				if ($urandom_range(0, 9) == 0) begin
					row.mask = $urandom;
				end else begin
					len = $urandom_range(0, 32);
					row.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
				end
				if ($urandom_range(0, 3) != 0) begin
					row.dest = prefix_pool[$urandom_range(0, 3)] ^ ($urandom & ~row.mask);
				end else begin
					row.dest = $urandom;
				end
				row.live = ($urandom_range(0, 99) < 85);
				if ($urandom_range(0, 3) != 0) begin
					row.addr = prefix_pool[$urandom_range(0, 3)] ^
						($urandom >> $urandom_range(0, 32));
				end else begin
					row.addr = $urandom;
				end
				issue_request(row);
			end
		end

		// Drain, then give the block a lookup's length to show anything extra.
		req_ch.valid <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (lpm_pkg::TABLE_DEPTH + 8) @(posedge clk);
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
